>>> rtl/kmer_set_match_counter_assert.svh
// assertion macros for the k-mer set match counter
// used by modules that check their own control logic; needs clk and arst_n in scope
`ifndef KMER_SET_MATCH_COUNTER_ASSERT_SVH
`define KMER_SET_MATCH_COUNTER_ASSERT_SVH
// same-cycle implication
`define KMS_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KMS_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/kms_pkg.sv
// shared types and constants of the k-mer set match counter
// no dependencies
`timescale 1ns / 1ps
package kms_pkg;
	localparam int ENTRIES = 1024;
	localparam int IDX_W = 10;
	localparam int MAX_K = 32;
	localparam int KLEN_W = 6;
	localparam int COUNT_BITS = 32;
	localparam int KEY_W = 64;
	localparam int TOTAL_W = 64;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_BASE = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	typedef enum logic [1:0] {JOB_PASS, JOB_LOAD, JOB_READ, JOB_SEARCH} job_kind_t;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN} back_state_t;

	typedef struct packed {
		job_kind_t          kind;
		logic               done;
		logic [IDX_W-1:0]   idx;
		logic [KEY_W-1:0]   key;
		logic [TOTAL_W-1:0] total;
	} job_t;

	typedef struct packed {
		logic                  done;
		logic                  matched;
		logic [IDX_W-1:0]      idx;
		logic [COUNT_BITS-1:0] cnt;
		logic [TOTAL_W-1:0]    total;
	} res_t;
endpackage

>>> rtl/kmer_set_match_counter.sv
// Counts k-mer windows of streamed read bases against a loaded table of reference keys.
// Slave beats (s_tvalid/s_tready) carry commands: tuser holds the command, tdata the
// base, slot and key. Master beats (m_tvalid/m_tready) carry one result per command.
// cfg_we/cfg_data write the window length (bases per k-mer); the user must write it only
// while the block is idle, the block itself does not enforce it. After reset a clearing
// pass over all 1024 slots empties the key and counter tables; s_tready stays low during it.
// End-of-read beats, bases that start no lookup and key loads give a result in the cycle
// after the job reaches the back end; readbacks pass the registered memory read and then
// the read state; a lookup sweeps the table one slot a cycle through the key memory read
// port, stopping at the lowest matching slot or after the last slot.
// A two-entry job queue decouples acceptance from execution, so up to two commands
// are taken while the back end works or while the result waits.
// A new job starts only after the held result has been taken: when m_tready is low
// the result register holds and the queue fills, then s_tready drops.
// Depends on kms_pkg, kms_front, kms_queue and kms_back.
`timescale 1ns / 1ps
module kmer_set_match_counter import kms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,  // base_code[2:0], entry_index[12:3], key_value[76:13]
	input  logic [1:0]        s_tuser,  // cmd[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [111:0]      m_tdata,  // match_index[9:0], entry_count[41:10], window_total[105:42]
	output logic [1:0]        m_tuser   // window_done[0], matched[1]
);
	job_t job;
	job_t head;
	logic accept, empty, full, pop, busy;
	res_t res;

	assign s_tready = !full && !busy;
	assign accept   = s_tvalid && s_tready;

	// command classification
	kms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.cmd         (s_tuser),
		.base_code   (s_tdata[2:0]),
		.entry_index (s_tdata[12:3]),
		.key_value   (s_tdata[76:13]),
		.job         (job)
	);

	// job queue
	kms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// table and lookup
	kms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.busy      (busy),
		.res       (res),
		.res_valid (m_tvalid),
		.res_ready (m_tready)
	);

	// result beat packing
	assign m_tdata = {6'd0, res.total, res.cnt, res.idx};
	assign m_tuser = {res.matched, res.done};
endmodule

>>> rtl/kms_front.sv
// front end: accepts beats, keeps the window state and classifies each item into a job
// depends on kms_pkg
`timescale 1ns / 1ps
module kms_front import kms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_data,
	input  logic              accept,
	input  logic [1:0]        cmd,
	input  logic [2:0]        base_code,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [KEY_W-1:0]  key_value,
	output job_t              job
);
	localparam logic [KLEN_W-1:0] KMAX = KLEN_W'(MAX_K);

	logic [KLEN_W-1:0]  klen_q;
	logic [KEY_W-1:0]   window_q;
	logic [KLEN_W-1:0]  bases_q;
	logic [KLEN_W-1:0]  clean_q;
	logic [TOTAL_W-1:0] total_q;

	logic [KLEN_W-1:0]  k;
	logic [KEY_W-1:0]   msk;
	logic               known;
	logic [KEY_W-1:0]   window_d;
	logic [KLEN_W-1:0]  bases_d;
	logic [KLEN_W-1:0]  clean_d;
	logic               done_d;

	// effective window length and key mask
	always_comb begin
		if (klen_q == '0) begin
			k = KLEN_W'(1);
		end else if (klen_q > KMAX) begin
			k = KMAX;
		end else begin
			k = klen_q;
		end
		if (k >= KLEN_W'(32)) begin
			msk = '1;
		end else begin
			msk = ~({KEY_W{1'b1}} << {k, 1'b0});
		end
	end

	// next window state for a base
	always_comb begin
		known    = (base_code < 3'd4);
		window_d = {window_q[KEY_W-3:0], known ? base_code[1:0] : 2'b00};
		bases_d  = (bases_q < KMAX) ? bases_q + KLEN_W'(1) : bases_q;
		if (known) begin
			clean_d = (clean_q < KMAX) ? clean_q + KLEN_W'(1) : clean_q;
		end else begin
			clean_d = '0;
		end
		done_d = (bases_d >= k);
	end

	// job classification
	always_comb begin
		job.kind  = JOB_PASS;
		job.done  = 1'b0;
		job.idx   = '0;
		job.key   = '0;
		job.total = total_q;
		unique case (cmd)
			CMD_LOAD: begin
				job.kind = JOB_LOAD;
				job.idx  = entry_index;
				job.key  = key_value & msk;
			end
			CMD_BASE: begin
				job.done  = done_d;
				job.total = total_q + TOTAL_W'(done_d);
				job.key   = window_d & msk;
				if (done_d && clean_d >= k) begin
					job.kind = JOB_SEARCH;
				end
			end
			CMD_END: begin
				job.kind = JOB_PASS;
			end
			CMD_READ: begin
				job.kind = JOB_READ;
				job.idx  = entry_index;
			end
			default: begin
				job.kind = JOB_PASS;
			end
		endcase
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_W'(31);
		end else if (cfg_we) begin
			klen_q <= cfg_data;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			bases_q  <= '0;
			clean_q  <= '0;
			total_q  <= '0;
		end else if (accept) begin
			if (cmd == CMD_BASE) begin
				window_q <= window_d;
				bases_q  <= bases_d;
				clean_q  <= clean_d;
				total_q  <= total_q + TOTAL_W'(done_d);
			end else if (cmd == CMD_END) begin
				window_q <= '0;
				bases_q  <= '0;
				clean_q  <= '0;
			end
		end
	end
endmodule

>>> rtl/kms_queue.sv
// two-entry job queue between front and back
// depends on kms_pkg
`timescale 1ns / 1ps
module kms_queue import kms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);
	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> rtl/kms_back.sv
// back end: key and counter memories, clearing pass, lookup sweep, result register
// depends on kms_pkg and kmer_set_match_counter_assert.svh
`timescale 1ns / 1ps
`include "kmer_set_match_counter_assert.svh"
module kms_back import kms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t head,
	input  logic empty,
	output logic pop,
	output logic busy,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	logic [KEY_W:0]      key_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

	back_state_t         state_q, state_d;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    scan_q;
	logic [IDX_W-1:0]    addr_s1;
	logic                rd_valid_s1;
	logic [KEY_W:0]      key_rd_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	job_t                job_q;
	res_t                out_q;
	logic                out_valid_q;

	logic                key_we, cnt_we;
	logic [IDX_W-1:0]    wa, ra;
	logic [KEY_W:0]      key_wd;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic                hit;
	logic                scan_last;
	logic                out_load;
	res_t                out_d;

	assign res       = out_q;
	assign res_valid = out_valid_q;
	assign busy      = (state_q == ST_CLEAR);
	assign hit       = rd_valid_s1 && key_rd_s1[KEY_W] && (key_rd_s1[KEY_W-1:0] == job_q.key);
	assign scan_last = rd_valid_s1 && (addr_s1 == LAST);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!empty && !out_valid_q) begin
					if (head.kind == JOB_READ) begin
						state_d = ST_READ;
					end else if (head.kind == JOB_SEARCH) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (hit || scan_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory control and result forming
	always_comb begin
		pop      = 1'b0;
		key_we   = 1'b0;
		cnt_we   = 1'b0;
		wa       = clr_q;
		key_wd   = '0;
		cnt_wd   = '0;
		ra       = scan_q;
		out_load = 1'b0;
		out_d    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				key_we = 1'b1;
				cnt_we = 1'b1;
			end
			ST_IDLE: begin
				ra = head.idx;
				if (!empty && !out_valid_q) begin
					pop = 1'b1;
					out_d.done  = head.done;
					out_d.total = head.total;
					if (head.kind == JOB_PASS) begin
						out_load = 1'b1;
					end else if (head.kind == JOB_LOAD) begin
						out_load  = 1'b1;
						out_d.idx = head.idx;
						key_we    = 1'b1;
						cnt_we    = 1'b1;
						wa        = head.idx;
						key_wd    = {1'b1, head.key};
					end
				end
			end
			ST_READ: begin
				out_load    = 1'b1;
				out_d.idx   = job_q.idx;
				out_d.cnt   = cnt_rd_s1;
				out_d.total = job_q.total;
			end
			ST_SCAN: begin
				out_d.done  = job_q.done;
				out_d.total = job_q.total;
				if (hit) begin
					out_load      = 1'b1;
					out_d.matched = 1'b1;
					out_d.idx     = addr_s1;
					out_d.cnt     = (cnt_rd_s1 == '1) ? cnt_rd_s1 : cnt_rd_s1 + COUNT_BITS'(1);
					cnt_we        = 1'b1;
					wa            = addr_s1;
					cnt_wd        = out_d.cnt;
				end else if (scan_last) begin
					out_load = 1'b1;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wa] <= key_wd;
		end
		key_rd_s1 <= key_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[wa] <= cnt_wd;
		end
		cnt_rd_s1 <= cnt_mem[ra];
	end

	// job and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			addr_s1     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (state_q == ST_SCAN) begin
				scan_q      <= scan_q + IDX_W'(1);
				addr_s1     <= scan_q;
				rd_valid_s1 <= 1'b1;
			end else begin
				scan_q      <= '0;
				rd_valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`KMS_IMP(a_match_has_window, out_valid_q && out_q.matched, out_q.done, "match without window")
	`KMS_IMP(a_no_pop_in_clear, state_q == ST_CLEAR, !pop && !out_load, "activity during clear")
	`KMS_NXT(a_scan_from_zero, pop && head.kind == JOB_SEARCH,
		state_q == ST_SCAN && scan_q == '0 && !rd_valid_s1, "sweep does not start at slot zero")
	`KMS_IMP(a_load_needs_room, out_load && state_q != ST_IDLE, !out_valid_q, "result overwritten")
endmodule
